@@ design/chmm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// chmm_pkg
// Shared types, register addresses and reset values for the handheld
// memory map block.
// ============================================================================
package chmm_pkg;

    localparam int CHMM_WORK_BANKS = 7;
    localparam int BANK_SIZE       = 4096;
    localparam int MAIN_DEPTH      = 32768;
    localparam int MAIN_AW         = 15;
    localparam int VRAM_DEPTH      = 8192;
    localparam int VRAM_AW         = 13;
    localparam int PAL_DEPTH       = 64;
    localparam int PAL_AW          = 6;

    localparam logic [15:0] ADDR_JOYP  = 16'hFF00;
    localparam logic [15:0] ADDR_SB    = 16'hFF01;
    localparam logic [15:0] ADDR_SC    = 16'hFF02;
    localparam logic [15:0] ADDR_DIV   = 16'hFF04;
    localparam logic [15:0] ADDR_DMA   = 16'hFF46;
    localparam logic [15:0] ADDR_KEY1  = 16'hFF4D;
    localparam logic [15:0] ADDR_VBK   = 16'hFF4F;
    localparam logic [15:0] ADDR_HDMA5 = 16'hFF55;
    localparam logic [15:0] ADDR_BCPS  = 16'hFF68;
    localparam logic [15:0] ADDR_BCPD  = 16'hFF69;
    localparam logic [15:0] ADDR_OCPS  = 16'hFF6A;
    localparam logic [15:0] ADDR_OCPD  = 16'hFF6B;
    localparam logic [15:0] ADDR_SVBK  = 16'hFF70;

    localparam logic [7:0] STATUS_BIT7 = 8'h80;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  button_state;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       serial_valid;
        logic [7:0] serial_byte;
        logic       cartridge_access;
    } t_out_item;

    // Source of the read data for the transaction in flight.
    typedef enum logic [2:0] {
        RS_ZERO  = 3'd0,
        RS_MAIN  = 3'd1,
        RS_SPEED = 3'd2,
        RS_VRAM  = 3'd3,
        RS_WORK  = 3'd4,
        RS_BGP   = 3'd5,
        RS_OBP   = 3'd6,
        RS_HDMA  = 3'd7
    } t_rsel;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic exec;
        logic load_out;
    } t_ctl_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } t_ctl_sts;

    // Power-up contents of the flat store, indexed by address minus 0x8000.
    function automatic logic [7:0] f_power_up(input logic [MAIN_AW-1:0] idx);
        logic [7:0] val;
        val = 8'h00;
        case ({1'b1, idx})
            16'hFF10: val = 8'h80;
            16'hFF11: val = 8'hBF;
            16'hFF12: val = 8'hF3;
            16'hFF14: val = 8'hBF;
            16'hFF16: val = 8'h3F;
            16'hFF19: val = 8'hBF;
            16'hFF1A: val = 8'h7F;
            16'hFF1B: val = 8'hFF;
            16'hFF1C: val = 8'h9F;
            16'hFF1E: val = 8'hBF;
            16'hFF20: val = 8'hFF;
            16'hFF23: val = 8'hBF;
            16'hFF24: val = 8'h77;
            16'hFF25: val = 8'hF3;
            16'hFF26: val = 8'hF1;
            16'hFF40: val = 8'h91;
            16'hFF47: val = 8'hFC;
            16'hFF48: val = 8'hFF;
            16'hFF49: val = 8'hFF;
            default:  val = 8'h00;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

@@ design/chmm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// chmm_ctrl
// Sequencer: runs the post-reset clearing pass, then steps each transaction
// through accept, execute and result hand-off.
// ============================================================================
module chmm_ctrl
    import chmm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_ctl_sts i_sts,
    output t_ctl_cmd      o_cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_EXEC  = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                // The result waits here until the output register is free.
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ design/chmm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// chmm_datapath
// Address decode, storage arrays, shadow IO registers and the output
// register of the memory map.
// ============================================================================
module chmm_datapath
    import chmm_pkg::*;
#(
    parameter int WORK_BANKS = CHMM_WORK_BANKS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_ctl_cmd i_cmd,
    output t_ctl_sts      o_sts,
    input  wire t_in_item i_in_data,
    input  wire logic     i_cfg_valid,
    input  wire logic     i_cfg_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    localparam int WB_DEPTH = WORK_BANKS * BANK_SIZE;
    localparam int WB_AW    = $clog2(WB_DEPTH);
    localparam logic [2:0] WB_LAST = 3'(WORK_BANKS - 1);
    localparam logic [MAIN_AW-1:0] WB_END = MAIN_AW'(WB_DEPTH);

    // Storage arrays.
    logic [7:0] r_main [MAIN_DEPTH];
    logic [7:0] r_vram [VRAM_DEPTH];
    logic [7:0] r_work [WB_DEPTH];
    logic [7:0] r_bgp  [PAL_DEPTH];
    logic [7:0] r_obp  [PAL_DEPTH];

    logic [7:0] r_main_q, r_vram_q, r_work_q, r_bgp_q, r_obp_q;

    // Shadow copies of the IO bytes the decode needs every cycle.
    logic [2:0] r_svbk;
    logic       r_vbk;
    logic [7:0] r_bcps;
    logic [7:0] r_ocps;
    logic [7:0] r_sb;
    logic       r_color_mode;

    logic [MAIN_AW-1:0] r_clr;
    t_in_item           r_in;
    t_rsel              r_rsel;
    logic               r_ser_v;
    logic [7:0]         r_ser_b;
    logic               r_cart;
    logic               r_out_valid;
    t_out_item          r_out;

    // Execute-cycle decode results.
    logic               x_main_we;
    logic [MAIN_AW-1:0] x_main_addr;
    logic [7:0]         x_main_data;
    logic               x_vram_we, x_work_we, x_bgp_we, x_obp_we;
    t_rsel              x_rsel;
    logic               x_ser_v;
    logic               x_cart;
    logic [2:0]         x_slot;
    logic [MAIN_AW-1:0] x_work_full;
    logic [WB_AW-1:0]   x_work_idx;
    logic [7:0]         x_joyp;

    // Memory write ports, shared by the clearing pass and execution.
    logic               m_main_we;
    logic [MAIN_AW-1:0] m_main_addr;
    logic [7:0]         m_main_data;
    logic               m_vram_we, m_work_we, m_pal_clr;
    logic [WB_AW-1:0]   m_work_addr;
    logic [7:0]         m_data;
    logic [7:0]         rd_byte;

    logic [15:0] a;
    logic        is_vram1, is_wram;

    assign a        = r_in.address;
    assign is_vram1 = (a[15:13] == 3'b100) && r_vbk;
    assign is_wram  = (a[15:12] == 4'hD);

    always_comb begin
        x_slot = (r_svbk == 3'd0) ? 3'd0 : (r_svbk - 3'd1);
        if (x_slot > WB_LAST) begin
            x_slot = WB_LAST;
        end
        x_work_full = {x_slot, a[11:0]};
        x_work_idx  = x_work_full[WB_AW-1:0];
    end

    always_comb begin
        x_joyp = r_in.write_data;
        if (!r_in.write_data[5] && r_in.write_data[4]) begin
            x_joyp = r_in.write_data | {4'h0, r_in.button_state[7:4]};
        end else if (!r_in.write_data[4] && r_in.write_data[5]) begin
            x_joyp = r_in.write_data | {4'h0, r_in.button_state[3:0]};
        end else begin
            x_joyp = r_in.write_data | 8'h0F;
        end
    end

    always_comb begin
        x_main_we   = 1'b0;
        x_main_addr = a[MAIN_AW-1:0];
        x_main_data = r_in.write_data;
        x_vram_we   = 1'b0;
        x_work_we   = 1'b0;
        x_bgp_we    = 1'b0;
        x_obp_we    = 1'b0;
        x_rsel      = RS_ZERO;
        x_ser_v     = 1'b0;
        x_cart      = 1'b0;
        if (!a[15]) begin
            x_cart = 1'b1;
        end else if (r_in.operation == OP_READ) begin
            if (a == ADDR_BCPD) begin
                x_rsel = RS_BGP;
            end else if (a == ADDR_OCPD) begin
                x_rsel = RS_OBP;
            end else if (r_color_mode && is_vram1) begin
                x_rsel = RS_VRAM;
            end else if (r_color_mode && is_wram) begin
                x_rsel = RS_WORK;
            end else if (r_color_mode && a == ADDR_KEY1) begin
                x_rsel = RS_SPEED;
            end else if (r_color_mode && a == ADDR_HDMA5) begin
                x_rsel = RS_HDMA;
            end else begin
                x_rsel = RS_MAIN;
            end
        end else if (a == ADDR_JOYP) begin
            x_main_we   = 1'b1;
            x_main_data = x_joyp;
        end else if (a == ADDR_SC) begin
            x_ser_v = 1'b1;
        end else if (a == ADDR_DIV) begin
            x_main_we   = 1'b1;
            x_main_data = 8'h00;
        end else if (a == ADDR_DMA) begin
            x_main_we = 1'b0;
        end else if (r_color_mode && is_vram1) begin
            x_vram_we = 1'b1;
        end else if (r_color_mode && is_wram) begin
            x_work_we = 1'b1;
        end else if (r_color_mode && a == ADDR_HDMA5) begin
            x_main_we = 1'b0;
        end else if (r_color_mode && a == ADDR_BCPD) begin
            x_bgp_we    = 1'b1;
            x_main_we   = r_bcps[7];
            x_main_addr = ADDR_BCPS[MAIN_AW-1:0];
            x_main_data = {r_bcps[7:6], r_bcps[5:0] + 6'd1};
        end else if (r_color_mode && a == ADDR_OCPD) begin
            x_obp_we    = 1'b1;
            x_main_we   = r_ocps[7];
            x_main_addr = ADDR_OCPS[MAIN_AW-1:0];
            x_main_data = {r_ocps[7:6], r_ocps[5:0] + 6'd1};
        end else begin
            x_main_we = 1'b1;
        end
    end

    always_comb begin
        m_pal_clr = i_cmd.clear_step;
        if (i_cmd.clear_step) begin
            m_main_we   = 1'b1;
            m_main_addr = r_clr;
            m_main_data = f_power_up(r_clr);
            m_vram_we   = 1'b1;
            m_work_we   = (r_clr < WB_END);
            m_work_addr = r_clr[WB_AW-1:0];
            m_data      = 8'h00;
        end else begin
            m_main_we   = i_cmd.exec && x_main_we;
            m_main_addr = x_main_addr;
            m_main_data = x_main_data;
            m_vram_we   = i_cmd.exec && x_vram_we;
            m_work_we   = i_cmd.exec && x_work_we;
            m_work_addr = x_work_idx;
            m_data      = r_in.write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_main_we) begin
            r_main[m_main_addr] <= m_main_data;
        end
        if (i_cmd.exec) begin
            r_main_q <= r_main[a[MAIN_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_vram_we) begin
            r_vram[i_cmd.clear_step ? r_clr[VRAM_AW-1:0] : a[VRAM_AW-1:0]] <= m_data;
        end
        if (i_cmd.exec) begin
            r_vram_q <= r_vram[a[VRAM_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_work_we) begin
            r_work[m_work_addr] <= m_data;
        end
        if (i_cmd.exec) begin
            r_work_q <= r_work[x_work_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_pal_clr || (i_cmd.exec && x_bgp_we)) begin
            r_bgp[m_pal_clr ? r_clr[PAL_AW-1:0] : r_bcps[PAL_AW-1:0]] <= m_data;
        end
        if (i_cmd.exec) begin
            r_bgp_q <= r_bgp[r_bcps[PAL_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_pal_clr || (i_cmd.exec && x_obp_we)) begin
            r_obp[m_pal_clr ? r_clr[PAL_AW-1:0] : r_ocps[PAL_AW-1:0]] <= m_data;
        end
        if (i_cmd.exec) begin
            r_obp_q <= r_obp[r_ocps[PAL_AW-1:0]];
        end
    end

    // Shadow registers follow every write that lands on their address.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svbk       <= '0;
            r_vbk        <= 1'b0;
            r_bcps       <= '0;
            r_ocps       <= '0;
            r_sb         <= '0;
            r_color_mode <= 1'b0;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_color_mode <= i_cfg_data;
            end
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + MAIN_AW'(1);
            end
            if (i_cmd.exec && x_main_we) begin
                priority case ({1'b1, x_main_addr})
                    ADDR_SVBK: r_svbk <= x_main_data[2:0];
                    ADDR_VBK:  r_vbk  <= x_main_data[0];
                    ADDR_BCPS: r_bcps <= x_main_data;
                    ADDR_OCPS: r_ocps <= x_main_data;
                    ADDR_SB:   r_sb   <= x_main_data;
                    default:   r_sb   <= r_sb;
                endcase
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_in <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_rsel  <= x_rsel;
            r_ser_v <= x_ser_v;
            r_ser_b <= x_ser_v ? r_sb : 8'h00;
            r_cart  <= x_cart;
        end
        if (i_cmd.load_out) begin
            r_out.read_data        <= rd_byte;
            r_out.serial_valid     <= r_ser_v;
            r_out.serial_byte      <= r_ser_b;
            r_out.cartridge_access <= r_cart;
        end
    end

    always_comb begin
        unique case (r_rsel)
            RS_ZERO:  rd_byte = 8'h00;
            RS_MAIN:  rd_byte = r_main_q;
            RS_SPEED: rd_byte = r_main_q[0] ? STATUS_BIT7 : 8'h00;
            RS_VRAM:  rd_byte = r_vram_q;
            RS_WORK:  rd_byte = r_work_q;
            RS_BGP:   rd_byte = r_bgp_q;
            RS_OBP:   rd_byte = r_obp_q;
            RS_HDMA:  rd_byte = STATUS_BIT7;
            default:  rd_byte = 8'h00;
        endcase
    end

    assign o_sts.clear_last = (r_clr == {MAIN_AW{1'b1}});
    assign o_sts.out_free   = !r_out_valid || i_out_ready;
    assign o_out_valid      = r_out_valid;
    assign o_out_data       = r_out;

endmodule
`default_nettype wire

@@ design/color_handheld_memory_map.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// color_handheld_memory_map
// CPU-side memory map for 0x8000-0xFFFF of a color handheld console: video
// and work-RAM banking, palette data ports, joypad, DIV and serial registers.
// ============================================================================
//
//  Channel   Direction  Handshake                   Payload
//  -------   ---------  --------------------------  -----------------------
//  in        to block   i_in_valid / o_in_ready     i_in_data  (t_in_item)
//  out       from block o_out_valid / i_out_ready   o_out_data (t_out_item)
//  cfg       to block   i_cfg_valid / o_cfg_ready   i_cfg_data (color mode)
//
//  Each transaction steps through accept, execute (memory access and
//  write-back) and hand-off to the output register; the next one is
//  accepted only after the previous one has been handed off.
//  After reset a clearing pass writes every entry of the 32 KiB flat store
//  (and of the banked RAMs and palettes) at one address per cycle, during
//  which o_in_ready stays low; configuration writes are taken.
//  A stalled output register holds the finished result; the sequencer waits
//  with the next result until that register is free.
//
module color_handheld_memory_map
    import chmm_pkg::*;
#(
    parameter int WORK_BANKS = CHMM_WORK_BANKS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic      i_cfg_data
);

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    // The color-mode register is a plain flop and can take a write any cycle.
    assign o_cfg_ready = 1'b1;

    // The sequencer decides when each stage of a transaction happens.
    chmm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds all storage, the decode and the output register.
    chmm_datapath #(
        .WORK_BANKS (WORK_BANKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

`ifndef ASSERT_OFF
    // No transaction is taken while the clearing pass is still running.
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear_step |-> !o_in_ready)
        else $error("input ready during clearing pass");

    // A result is only loaded when the output register can take it.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result overwrote a pending output");

    // An accepted transaction blocks the input until its result is handed off.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second transaction accepted while one is in flight");

    // A serial emission is a write: no read data and no cartridge flag.
    a_serial_is_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.serial_valid) |->
            (o_out_data.read_data == 8'h00 && !o_out_data.cartridge_access))
        else $error("serial result carries read data");
`endif

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the handheld memory map. A scoreboard class keeps
// its own copy of every store and register, predicts the response of each
// accepted bus access, and compares the responses field by field.
// ============================================================================
module tb;
    import chmm_pkg::*;

    // Number of cycles the response side holds off during the back-pressure phase.
    localparam int LONG_HOLD       = 400;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 135;

    // ------------------------------------------------------------------------
    // Scoreboard. It owns a full shadow of the address space: the flat store
    // with its power-up values, video bank 1, the work-RAM banks and both
    // palettes, plus the color-mode register. Each accepted access is run
    // through the shadow at once, and the response it should give is queued.
    // ------------------------------------------------------------------------
    class bus_map_scoreboard;
        bit [7:0]  flat_mem   [MAIN_DEPTH];
        bit [7:0]  vram_bank1 [VRAM_DEPTH];
        bit [7:0]  wram_banks [CHMM_WORK_BANKS * BANK_SIZE];
        bit [7:0]  bg_pal     [PAL_DEPTH];
        bit [7:0]  obj_pal    [PAL_DEPTH];
        bit        color_mode;
        t_out_item expected_responses[$];
        int        mismatch_count;

        function new();
            poke(16'hFF10, 8'h80); poke(16'hFF11, 8'hBF); poke(16'hFF12, 8'hF3);
            poke(16'hFF14, 8'hBF); poke(16'hFF16, 8'h3F); poke(16'hFF19, 8'hBF);
            poke(16'hFF1A, 8'h7F); poke(16'hFF1B, 8'hFF); poke(16'hFF1C, 8'h9F);
            poke(16'hFF1E, 8'hBF); poke(16'hFF20, 8'hFF); poke(16'hFF23, 8'hBF);
            poke(16'hFF24, 8'h77); poke(16'hFF25, 8'hF3); poke(16'hFF26, 8'hF1);
            poke(16'hFF40, 8'h91); poke(16'hFF47, 8'hFC); poke(16'hFF48, 8'hFF);
            poke(16'hFF49, 8'hFF);
        endfunction

        function void poke(logic [15:0] addr, logic [7:0] val);
            flat_mem[addr[14:0]] = val;
        endfunction

        function logic [7:0] peek(logic [15:0] addr);
            return flat_mem[addr[14:0]];
        endfunction

        function void set_color_mode(logic mode);
            color_mode = mode;
        endfunction

        function int pending();
            return expected_responses.size();
        endfunction

        function bit vram1_selected(logic [15:0] addr);
            logic [7:0] vbk;
            vbk = peek(ADDR_VBK);
            return addr[15:13] == 3'b100 && vbk[0];
        endfunction

        // Bank 0 behaves as bank 1; banks past the last slot fold onto it.
        function int work_index(logic [15:0] addr);
            int         slot;
            logic [7:0] svbk;
            svbk = peek(ADDR_SVBK);
            slot = int'(svbk[2:0]);
            if (slot > 0) slot--;
            if (slot >= CHMM_WORK_BANKS) slot = CHMM_WORK_BANKS - 1;
            return slot * BANK_SIZE + int'(addr[11:0]);
        endfunction

        function logic [7:0] read_byte(logic [15:0] addr);
            logic [7:0] bcps;
            logic [7:0] ocps;
            logic [7:0] stored;
            bcps   = peek(ADDR_BCPS);
            ocps   = peek(ADDR_OCPS);
            stored = peek(addr);
            if (addr == ADDR_BCPD) return bg_pal[bcps[5:0]];
            if (addr == ADDR_OCPD) return obj_pal[ocps[5:0]];
            if (color_mode) begin
                if (vram1_selected(addr)) return vram_bank1[addr[12:0]];
                if (addr[15:12] == 4'hD) return wram_banks[work_index(addr)];
                if (addr == ADDR_KEY1) return stored[0] ? STATUS_BIT7 : 8'h00;
                if (addr == ADDR_HDMA5) return STATUS_BIT7;
            end
            return stored;
        endfunction

        // Palette data write; the index register steps only when its bit 7 is set.
        function void palette_store(bit sprite, logic [7:0] val);
            logic [15:0] idx_addr;
            logic [7:0]  idx;
            idx_addr = sprite ? ADDR_OCPS : ADDR_BCPS;
            idx      = peek(idx_addr);
            if (sprite) obj_pal[idx[5:0]] = val;
            else        bg_pal[idx[5:0]]  = val;
            if (idx[7]) poke(idx_addr, {idx[7:6], idx[5:0] + 6'd1});
        endfunction

        function t_out_item predict(t_in_item acc);
            t_out_item   res;
            logic [15:0] addr;
            logic [7:0]  val;
            bit          sel_btn;
            bit          sel_dir;
            res  = '0;
            addr = acc.address;
            val  = acc.write_data;
            if (!addr[15]) begin
                res.cartridge_access = 1'b1;
                return res;
            end
            if (acc.operation == OP_READ) begin
                res.read_data = read_byte(addr);
                return res;
            end
            case (addr)
                ADDR_JOYP: begin
                    sel_btn = !val[5];
                    sel_dir = !val[4];
                    if (sel_btn && !sel_dir)      val = val | {4'h0, acc.button_state[7:4]};
                    else if (sel_dir && !sel_btn) val = val | {4'h0, acc.button_state[3:0]};
                    else                          val = val | 8'h0F;
                    poke(addr, val);
                    return res;
                end
                ADDR_SC: begin
                    res.serial_valid = 1'b1;
                    res.serial_byte  = peek(ADDR_SB);
                    return res;
                end
                ADDR_DIV: begin
                    poke(addr, 8'h00);
                    return res;
                end
                ADDR_DMA: return res;
                default: ;
            endcase
            if (color_mode) begin
                if (vram1_selected(addr)) begin
                    vram_bank1[addr[12:0]] = val;
                    return res;
                end
                if (addr[15:12] == 4'hD) begin
                    wram_banks[work_index(addr)] = val;
                    return res;
                end
                if (addr == ADDR_HDMA5) return res;
                if (addr == ADDR_BCPD) begin
                    palette_store(1'b0, val);
                    return res;
                end
                if (addr == ADDR_OCPD) begin
                    palette_store(1'b1, val);
                    return res;
                end
            end
            poke(addr, val);
            return res;
        endfunction

        function void note_access(t_in_item acc);
            expected_responses.push_back(predict(acc));
        endfunction

        function void check_response(t_out_item got);
            t_out_item want;
            if (expected_responses.size() == 0) begin
                $error("response with no access outstanding: %h", got);
                mismatch_count++;
                return;
            end
            want = expected_responses.pop_front();
            if (got.read_data !== want.read_data) begin
                $error("read_data: expected %h, got %h", want.read_data, got.read_data);
                mismatch_count++;
            end
            if (got.serial_valid !== want.serial_valid) begin
                $error("serial_valid: expected %b, got %b",
                       want.serial_valid, got.serial_valid);
                mismatch_count++;
            end
            if (got.serial_byte !== want.serial_byte) begin
                $error("serial_byte: expected %h, got %h", want.serial_byte, got.serial_byte);
                mismatch_count++;
            end
            if (got.cartridge_access !== want.cartridge_access) begin
                $error("cartridge_access: expected %b, got %b",
                       want.cartridge_access, got.cartridge_access);
                mismatch_count++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      i_out_ready = 1'b0;
    logic      i_cfg_valid = 1'b0;
    logic      i_cfg_data  = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      o_cfg_ready;

    bus_map_scoreboard sb = new();

    // Both sides run without gaps while this is set.
    bit fast_phase    = 1'b0;
    // Set by the stimulus to make the response side hold off for one LONG_HOLD stretch.
    bit hold_requests = 1'b0;

    color_handheld_memory_map dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Access drivers. A transaction is recorded in the scoreboard by the same
    // process that drives it, at the edge where it is accepted, so the count
    // of outstanding responses never lags behind the stimulus.
    // ------------------------------------------------------------------------
    function automatic t_in_item bus_access(logic op, logic [15:0] addr,
                                            logic [7:0] data, logic [7:0] pad);
        t_in_item acc;
        acc.operation    = op;
        acc.address      = addr;
        acc.write_data   = data;
        acc.button_state = pad;
        return acc;
    endfunction

    // Offsets close to either end of a window, so reads tend to hit earlier writes.
    function automatic logic [15:0] near_ends(int span);
        if ($urandom_range(0, 1)) return 16'($urandom_range(0, 7));
        return 16'(span - $urandom_range(0, 7));
    endfunction

    // Random access, weighted toward the registers and windows with behavior
    // of their own; one class covers the whole address range so every bit toggles.
    function automatic t_in_item random_access();
        t_in_item acc;
        acc.operation    = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
        acc.write_data   = 8'($urandom_range(0, 255));
        acc.button_state = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 15))
            0:       acc.address = 16'($urandom_range(0, 16'h7FFF));
            1:       acc.address = 16'($urandom_range(0, 16'hFFFF));
            2, 3:    acc.address = 16'h8000 + near_ends(16'h1FFF);
            4:       acc.address = ADDR_VBK;
            5, 6:    acc.address = 16'hD000 + near_ends(16'h0FFF);
            7:       acc.address = ADDR_SVBK;
            8:       acc.address = $urandom_range(0, 1) ? ADDR_BCPS : ADDR_OCPS;
            9:       acc.address = $urandom_range(0, 1) ? ADDR_BCPD : ADDR_OCPD;
            10:      acc.address = ADDR_JOYP;
            11: begin
                case ($urandom_range(0, 2))
                    0:       acc.address = ADDR_SB;
                    1:       acc.address = ADDR_SC;
                    default: acc.address = ADDR_DIV;
                endcase
            end
            12: begin
                case ($urandom_range(0, 2))
                    0:       acc.address = ADDR_DMA;
                    1:       acc.address = ADDR_KEY1;
                    default: acc.address = ADDR_HDMA5;
                endcase
            end
            13:      acc.address = 16'hFF00 + 16'($urandom_range(0, 127));
            14:      acc.address = 16'hFF80 + 16'($urandom_range(0, 127));
            default: acc.address = 16'hC000 + near_ends(16'h0FFF);
        endcase
        // Bank, index and joypad registers are mostly written, to keep state moving.
        if (acc.address inside {ADDR_VBK, ADDR_SVBK, ADDR_BCPS, ADDR_OCPS, ADDR_JOYP}
                && $urandom_range(0, 3) != 0)
            acc.operation = OP_WRITE;
        return acc;
    endfunction

    // Offers one access. Valid stays high on return so a back-to-back access
    // needs no second assignment in the same step; callers lower it when idle.
    task automatic send_access(input t_in_item acc);
        int gap;
        gap = fast_phase ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= acc;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_access(acc);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // The color-mode register is only written with no access in flight.
    task automatic write_color_mode(input logic mode);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_color_mode(mode);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Response side. It stalls a random number of cycles before each
    // transaction, and on request holds off for one long stretch so the
    // block fills up and pushes back on its input.
    // ------------------------------------------------------------------------
    initial begin : response_sink
        int stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_requests) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_requests = 1'b0;
            end
            stall = fast_phase ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_response(o_out_data);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. Directed passes in the two modes cover the cartridge region,
    // the ends of the address range, the joypad merge cases, serial, DIV and
    // copy triggers, status reads, both bank selects and palette
    // auto-increment with wrap. Random phases then alternate the mode and
    // vary the idling: one runs flat out, one stalls the response side for a
    // long stretch, one pauses the input until all responses are back.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Monochrome mode first; the write lands during the clearing pass.
        write_color_mode(1'b0);
        send_access(bus_access(OP_READ,  16'hFF26, 8'h00, 8'h00));
        send_access(bus_access(OP_WRITE, 16'h0000, 8'hFF, 8'hFF));
        send_access(bus_access(OP_READ,  16'h7FFF, 8'h00, 8'h00));
        send_access(bus_access(OP_WRITE, 16'hFFFF, 8'hFF, 8'h00));
        send_access(bus_access(OP_READ,  16'hFFFF, 8'h00, 8'h00));
        send_access(bus_access(OP_WRITE, ADDR_JOYP, 8'h10, 8'hA5));
        send_access(bus_access(OP_WRITE, ADDR_JOYP, 8'h20, 8'h5A));
        send_access(bus_access(OP_WRITE, ADDR_JOYP, 8'h00, 8'hF0));
        send_access(bus_access(OP_READ,  ADDR_JOYP, 8'h00, 8'h00));
        send_access(bus_access(OP_WRITE, ADDR_SB,   8'h5C, 8'h00));
        send_access(bus_access(OP_WRITE, ADDR_SC,   8'h81, 8'h00));
        send_access(bus_access(OP_WRITE, ADDR_DIV,  8'h77, 8'h00));
        send_access(bus_access(OP_READ,  ADDR_DIV,  8'h00, 8'h00));
        send_access(bus_access(OP_WRITE, ADDR_DMA,  8'h12, 8'h00));
        send_access(bus_access(OP_READ,  ADDR_BCPD, 8'h00, 8'h00));
        send_access(bus_access(OP_READ,  ADDR_KEY1, 8'h00, 8'h00));

        // Color mode: banking, status reads and palette auto-increment.
        write_color_mode(1'b1);
        send_access(bus_access(OP_WRITE, ADDR_VBK,  8'h01, 8'h00));
        send_access(bus_access(OP_WRITE, 16'h9FFF,  8'hC3, 8'h00));
        send_access(bus_access(OP_READ,  16'h9FFF,  8'h00, 8'h00));
        send_access(bus_access(OP_WRITE, ADDR_SVBK, 8'h07, 8'h00));
        send_access(bus_access(OP_WRITE, 16'hDFFF,  8'h22, 8'h00));
        send_access(bus_access(OP_READ,  16'hDFFF,  8'h00, 8'h00));
        send_access(bus_access(OP_WRITE, ADDR_SVBK, 8'h00, 8'h00));
        send_access(bus_access(OP_READ,  16'hDFFF,  8'h00, 8'h00));
        send_access(bus_access(OP_WRITE, ADDR_BCPS, 8'hBF, 8'h00));
        send_access(bus_access(OP_WRITE, ADDR_BCPD, 8'h3C, 8'h00));
        send_access(bus_access(OP_WRITE, ADDR_BCPD, 8'hE1, 8'h00));
        send_access(bus_access(OP_READ,  ADDR_BCPS, 8'h00, 8'h00));
        send_access(bus_access(OP_WRITE, ADDR_KEY1, 8'h01, 8'h00));
        send_access(bus_access(OP_READ,  ADDR_KEY1, 8'h00, 8'h00));
        send_access(bus_access(OP_READ,  ADDR_HDMA5, 8'h00, 8'h00));

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_color_mode(ph % 2 == 0);
            fast_phase = (ph == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 2 && n == 20) hold_requests = 1'b1;
                if (ph == 3 && n == ITEMS_PER_PHASE / 2) wait_drained();
                send_access(random_access());
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // The slowest correct run, clearing pass included, ends well before this timeout.
    initial begin : watchdog
        #3_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
design/chmm_pkg.sv
design/chmm_ctrl.sv
design/chmm_datapath.sv
design/color_handheld_memory_map.sv
dv/tb.sv
